FILE: rtl/core/peu_pkg.sv
// Shared types, widths and helpers for the particle Euler update pipeline.
package peu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_W          = 15;
  localparam int AGE_W         = 31;
  localparam int VAL_W         = 32;
  localparam int TS_RESET      = 1092;

  typedef struct packed {
    logic [AGE_W-1:0] age_now;
    logic [AGE_W-1:0] lifetime;
    logic [VAL_W-1:0] pos_x;
    logic [VAL_W-1:0] pos_y;
    logic [VAL_W-1:0] pos_z;
    logic [VAL_W-1:0] vel_x;
    logic [VAL_W-1:0] vel_y;
    logic [VAL_W-1:0] vel_z;
    logic [VAL_W-1:0] angle;
    logic [VAL_W-1:0] spin_rate;
    logic [AGE_W-1:0] drag_coeff;
    logic [VAL_W-1:0] gravity_scale;
  } peu_in_t;

  typedef struct packed {
    logic             expired;
    logic [AGE_W-1:0] age;
    logic [VAL_W-1:0] pos_x;
    logic [VAL_W-1:0] pos_y;
    logic [VAL_W-1:0] pos_z;
    logic [VAL_W-1:0] vel_x;
    logic [VAL_W-1:0] vel_y;
    logic [VAL_W-1:0] vel_z;
    logic [VAL_W-1:0] angle;
  } peu_rec_t;

  // Saturates a wide signed value to the signed 32-bit range.
  function automatic logic [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic [VAL_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/peu_cfg.sv
// Time step register with the quarter-second cap applied on write.
module peu_cfg #(
  parameter int FRAC_BITS = peu_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic [peu_pkg::DT_W-1:0] cfg_data,
  output logic [peu_pkg::DT_W-1:0] dt
);

  localparam longint CAP = longint'(1) << (FRAC_BITS - 2);
  localparam logic [peu_pkg::DT_W-1:0] DT_RST =
    peu_pkg::DT_W'((longint'(peu_pkg::TS_RESET) > CAP) ? CAP : longint'(peu_pkg::TS_RESET));

  logic [peu_pkg::DT_W-1:0] dt_r;
  logic [peu_pkg::DT_W-1:0] dt_nxt;

  // The capped step is stored so the pipeline never has to clamp it.
  always_comb begin
    if (longint'(cfg_data) > CAP) begin
      dt_nxt = peu_pkg::DT_W'(CAP);
    end else begin
      dt_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DT_RST;
    end else if (cfg_valid) begin
      dt_r <= dt_nxt;
    end
  end

  assign dt = dt_r;

endmodule

FILE: rtl/core/peu_dyn.sv
// Front stages: age and expiry, damping factor, gravity step and angle update.
module peu_dyn #(
  parameter int FRAC_BITS = peu_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [peu_pkg::DT_W-1:0] dt,
  input  logic                     i_valid,
  output logic                     i_ready,
  input  peu_pkg::peu_in_t         i_item,
  output logic                     o_valid,
  input  logic                     o_ready,
  output peu_pkg::peu_rec_t        o_rec,
  output logic [FRAC_BITS:0]       o_damp
);

  localparam int     DTS_W    = peu_pkg::DT_W + 1;
  localparam longint ONE      = longint'(1) << FRAC_BITS;
  localparam longint GRAV_MAG = (981 * ONE + 50) / 100;
  localparam int     GW       = FRAC_BITS + 5;
  localparam logic signed [GW-1:0] NEG_G = GW'(-GRAV_MAG);
  localparam int     PD_W     = peu_pkg::AGE_W + peu_pkg::DT_W;
  localparam int     PG_W     = peu_pkg::VAL_W + GW;
  localparam int     G1_W     = PG_W - FRAC_BITS;
  localparam int     G2_W     = G1_W + DTS_W;
  localparam int     PS_W     = peu_pkg::VAL_W + DTS_W;

  logic signed [DTS_W-1:0] dt_s;
  assign dt_s = $signed({1'b0, dt});

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3     = !v3_r || o_ready;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign i_ready = en1;
  assign o_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= i_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage 1: new age, expiry and the three products that only need inputs.
  logic [peu_pkg::AGE_W:0]   age_sum;
  logic [peu_pkg::AGE_W-1:0] nage;
  peu_pkg::peu_rec_t         rec1_nxt, rec1_r;
  logic [PD_W-1:0]           pdrag1_nxt, pdrag1_r;
  logic signed [PG_W-1:0]    pg1_nxt, pg1_r;
  logic signed [PS_W-1:0]    pspin1_nxt, pspin1_r;

  always_comb begin
    age_sum = {1'b0, i_item.age_now} + (peu_pkg::AGE_W + 1)'(dt);
    nage    = age_sum[peu_pkg::AGE_W] ? '1 : age_sum[peu_pkg::AGE_W-1:0];

    rec1_nxt         = '0;
    rec1_nxt.expired = (dt != '0) && (nage >= i_item.lifetime);
    rec1_nxt.age     = nage;
    rec1_nxt.pos_x   = i_item.pos_x;
    rec1_nxt.pos_y   = i_item.pos_y;
    rec1_nxt.pos_z   = i_item.pos_z;
    rec1_nxt.vel_x   = i_item.vel_x;
    rec1_nxt.vel_y   = i_item.vel_y;
    rec1_nxt.vel_z   = i_item.vel_z;
    rec1_nxt.angle   = i_item.angle;

    pdrag1_nxt = PD_W'(i_item.drag_coeff) * PD_W'(dt);
    pg1_nxt    = PG_W'($signed(i_item.gravity_scale)) * PG_W'(NEG_G);
    pspin1_nxt = PS_W'($signed(i_item.spin_rate)) * PS_W'(dt_s);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      rec1_r   <= rec1_nxt;
      pdrag1_r <= pdrag1_nxt;
      pg1_r    <= pg1_nxt;
      pspin1_r <= pspin1_nxt;
    end
  end

  // Stage 2: damping factor, gravity times step, angle integration.
  logic [PD_W-1:0]        dq;
  logic signed [G1_W-1:0] g1;
  peu_pkg::peu_rec_t      rec2_nxt, rec2_r;
  logic [FRAC_BITS:0]     damp2_nxt, damp2_r, damp3_r;
  logic signed [G2_W-1:0] g2_nxt, g2_r;

  always_comb begin
    dq = pdrag1_r >> FRAC_BITS;
    // Drag times step at or above one second of decay clamps the factor at zero.
    if (dq >= PD_W'(ONE)) begin
      damp2_nxt = '0;
    end else begin
      damp2_nxt = (FRAC_BITS + 1)'(PD_W'(ONE) - dq);
    end
    g1       = G1_W'(pg1_r >>> FRAC_BITS);
    g2_nxt   = G2_W'(g1) * G2_W'(dt_s);
    rec2_nxt = rec1_r;
    rec2_nxt.angle = peu_pkg::sat32(64'($signed(rec1_r.angle))
                                    + 64'(pspin1_r >>> FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      rec2_r  <= rec2_nxt;
      damp2_r <= damp2_nxt;
      g2_r    <= g2_nxt;
    end
  end

  // Stage 3: gravity step added to the vertical velocity.
  peu_pkg::peu_rec_t rec3_nxt, rec3_r;

  always_comb begin
    rec3_nxt       = rec2_r;
    rec3_nxt.vel_y = peu_pkg::sat32(64'($signed(rec2_r.vel_y)) + 64'(g2_r >>> FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rec3_r  <= rec3_nxt;
      damp3_r <= damp2_r;
    end
  end

  assign o_rec  = rec3_r;
  assign o_damp = damp3_r;

endmodule

FILE: rtl/core/peu_vel.sv
// Velocity damping stages: multiply by the damping factor, then scale and saturate.
module peu_vel #(
  parameter int FRAC_BITS = peu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               i_valid,
  output logic               i_ready,
  input  peu_pkg::peu_rec_t  i_rec,
  input  logic [FRAC_BITS:0] i_damp,
  output logic               o_valid,
  input  logic               o_ready,
  output peu_pkg::peu_rec_t  o_rec
);

  localparam int PV_W = peu_pkg::VAL_W + FRAC_BITS + 2;

  logic v4_r, v5_r;
  logic en4, en5;

  assign en5     = !v5_r || o_ready;
  assign en4     = !v4_r || en5;
  assign i_ready = en4;
  assign o_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) begin
        v4_r <= i_valid;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
    end
  end

  logic signed [FRAC_BITS+1:0] damp_s;
  logic signed [PV_W-1:0]      pvx_nxt, pvy_nxt, pvz_nxt;
  logic signed [PV_W-1:0]      pvx_r, pvy_r, pvz_r;
  peu_pkg::peu_rec_t           rec4_r, rec5_nxt, rec5_r;

  always_comb begin
    damp_s  = $signed({1'b0, i_damp});
    pvx_nxt = PV_W'($signed(i_rec.vel_x)) * PV_W'(damp_s);
    pvy_nxt = PV_W'($signed(i_rec.vel_y)) * PV_W'(damp_s);
    pvz_nxt = PV_W'($signed(i_rec.vel_z)) * PV_W'(damp_s);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      rec4_r <= i_rec;
      pvx_r  <= pvx_nxt;
      pvy_r  <= pvy_nxt;
      pvz_r  <= pvz_nxt;
    end
  end

  always_comb begin
    rec5_nxt       = rec4_r;
    rec5_nxt.vel_x = peu_pkg::sat32(64'(pvx_r >>> FRAC_BITS));
    rec5_nxt.vel_y = peu_pkg::sat32(64'(pvy_r >>> FRAC_BITS));
    rec5_nxt.vel_z = peu_pkg::sat32(64'(pvz_r >>> FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      rec5_r <= rec5_nxt;
    end
  end

  assign o_rec = rec5_r;

endmodule

FILE: rtl/core/peu_pos.sv
// Position stages: velocity times step, then add, saturate and clear expired records.
module peu_pos #(
  parameter int FRAC_BITS = peu_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [peu_pkg::DT_W-1:0] dt,
  input  logic                     i_valid,
  output logic                     i_ready,
  input  peu_pkg::peu_rec_t        i_rec,
  output logic                     o_valid,
  input  logic                     o_ready,
  output peu_pkg::peu_rec_t        o_rec
);

  localparam int DTS_W = peu_pkg::DT_W + 1;
  localparam int PP_W  = peu_pkg::VAL_W + DTS_W;

  logic v6_r, v7_r;
  logic en6, en7;

  assign en7     = !v7_r || o_ready;
  assign en6     = !v6_r || en7;
  assign i_ready = en6;
  assign o_valid = v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en6) begin
        v6_r <= i_valid;
      end
      if (en7) begin
        v7_r <= v6_r;
      end
    end
  end

  logic signed [DTS_W-1:0] dt_s;
  logic signed [PP_W-1:0]  pdx_nxt, pdy_nxt, pdz_nxt;
  logic signed [PP_W-1:0]  pdx_r, pdy_r, pdz_r;
  peu_pkg::peu_rec_t       rec6_r, rec7_nxt, rec7_r;

  always_comb begin
    dt_s    = $signed({1'b0, dt});
    pdx_nxt = PP_W'($signed(i_rec.vel_x)) * PP_W'(dt_s);
    pdy_nxt = PP_W'($signed(i_rec.vel_y)) * PP_W'(dt_s);
    pdz_nxt = PP_W'($signed(i_rec.vel_z)) * PP_W'(dt_s);
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      rec6_r <= i_rec;
      pdx_r  <= pdx_nxt;
      pdy_r  <= pdy_nxt;
      pdz_r  <= pdz_nxt;
    end
  end

  always_comb begin
    rec7_nxt       = rec6_r;
    rec7_nxt.pos_x = peu_pkg::sat32(64'($signed(rec6_r.pos_x)) + 64'(pdx_r >>> FRAC_BITS));
    rec7_nxt.pos_y = peu_pkg::sat32(64'($signed(rec6_r.pos_y)) + 64'(pdy_r >>> FRAC_BITS));
    rec7_nxt.pos_z = peu_pkg::sat32(64'($signed(rec6_r.pos_z)) + 64'(pdz_r >>> FRAC_BITS));
    // An expired particle keeps only its age; the rest of the record reads zero.
    if (rec6_r.expired) begin
      rec7_nxt         = '0;
      rec7_nxt.expired = 1'b1;
      rec7_nxt.age     = rec6_r.age;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      rec7_r <= rec7_nxt;
    end
  end

  assign o_rec = rec7_r;

endmodule

FILE: rtl/core/particle_euler_update.sv
// Top level of the particle Euler update pipeline.
//
// One particle record plus its emitter's drag and gravity scale enter on the
// in_ channel; the record after one time step leaves on the out_ channel.
// Both channels use valid/ready and a transaction completes when both are high.
// The cfg_ channel writes the time step; steps above a quarter second are
// stored as a quarter second. It is always ready and should only be written
// while no transaction is in flight.
// An accepted input transaction passes through all stage registers before
// out_valid rises for its result. The work is a seven-stage register pipeline
// (products, damping and gravity, velocity scaling, position update), so one
// record is taken every cycle unless a stalled output has filled the pipeline.
// Each stage carries its own valid bit; when out_ready is low the pipeline
// fills its empty stages and in_ready drops only once every stage holds a
// record. Nothing is dropped or duplicated during a stall.
// Synchronous reset empties the pipeline and sets the step to 1092 (about
// 1/60 s at 16 fractional bits, capped for smaller fractions).
module particle_euler_update #(
  parameter int FRAC_BITS = peu_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [peu_pkg::DT_W-1:0]  cfg_data,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [peu_pkg::AGE_W-1:0] in_age_now,
  input  logic [peu_pkg::AGE_W-1:0] in_lifetime,
  input  logic signed [31:0]        in_pos_x,
  input  logic signed [31:0]        in_pos_y,
  input  logic signed [31:0]        in_pos_z,
  input  logic signed [31:0]        in_vel_x,
  input  logic signed [31:0]        in_vel_y,
  input  logic signed [31:0]        in_vel_z,
  input  logic signed [31:0]        in_angle,
  input  logic signed [31:0]        in_spin_rate,
  input  logic [peu_pkg::AGE_W-1:0] in_drag_coeff,
  input  logic signed [31:0]        in_gravity_scale,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_expired,
  output logic [peu_pkg::AGE_W-1:0] out_new_age,
  output logic signed [31:0]        out_new_pos_x,
  output logic signed [31:0]        out_new_pos_y,
  output logic signed [31:0]        out_new_pos_z,
  output logic signed [31:0]        out_new_vel_x,
  output logic signed [31:0]        out_new_vel_y,
  output logic signed [31:0]        out_new_vel_z,
  output logic signed [31:0]        out_new_angle
);

  logic [peu_pkg::DT_W-1:0] dt;
  peu_pkg::peu_in_t         in_item;
  peu_pkg::peu_rec_t        dyn_rec, vel_rec, pos_rec;
  logic [FRAC_BITS:0]       dyn_damp;
  logic                     dyn_valid, dyn_ready, vel_valid, vel_ready;

  assign cfg_ready = 1'b1;

  peu_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .dt        (dt)
  );

  always_comb begin
    in_item.age_now       = in_age_now;
    in_item.lifetime      = in_lifetime;
    in_item.pos_x         = in_pos_x;
    in_item.pos_y         = in_pos_y;
    in_item.pos_z         = in_pos_z;
    in_item.vel_x         = in_vel_x;
    in_item.vel_y         = in_vel_y;
    in_item.vel_z         = in_vel_z;
    in_item.angle         = in_angle;
    in_item.spin_rate     = in_spin_rate;
    in_item.drag_coeff    = in_drag_coeff;
    in_item.gravity_scale = in_gravity_scale;
  end

  peu_dyn #(.FRAC_BITS(FRAC_BITS)) u_dyn (
    .clk     (clk),
    .rst_n   (rst_n),
    .dt      (dt),
    .i_valid (in_valid),
    .i_ready (in_ready),
    .i_item  (in_item),
    .o_valid (dyn_valid),
    .o_ready (dyn_ready),
    .o_rec   (dyn_rec),
    .o_damp  (dyn_damp)
  );

  peu_vel #(.FRAC_BITS(FRAC_BITS)) u_vel (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (dyn_valid),
    .i_ready (dyn_ready),
    .i_rec   (dyn_rec),
    .i_damp  (dyn_damp),
    .o_valid (vel_valid),
    .o_ready (vel_ready),
    .o_rec   (vel_rec)
  );

  peu_pos #(.FRAC_BITS(FRAC_BITS)) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .dt      (dt),
    .i_valid (vel_valid),
    .i_ready (vel_ready),
    .i_rec   (vel_rec),
    .o_valid (out_valid),
    .o_ready (out_ready),
    .o_rec   (pos_rec)
  );

  assign out_expired   = pos_rec.expired;
  assign out_new_age   = pos_rec.age;
  assign out_new_pos_x = $signed(pos_rec.pos_x);
  assign out_new_pos_y = $signed(pos_rec.pos_y);
  assign out_new_pos_z = $signed(pos_rec.pos_z);
  assign out_new_vel_x = $signed(pos_rec.vel_x);
  assign out_new_vel_y = $signed(pos_rec.vel_y);
  assign out_new_vel_z = $signed(pos_rec.vel_z);
  assign out_new_angle = $signed(pos_rec.angle);

  // An expired record carries nothing but its age.
  a_expired_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired |-> out_new_pos_x == 0 && out_new_pos_y == 0 &&
      out_new_pos_z == 0 && out_new_vel_x == 0 && out_new_vel_y == 0 &&
      out_new_vel_z == 0 && out_new_angle == 0)
    else $error("expired record has nonzero fields");

  // With a zero step nothing can expire.
  a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dt == '0 |-> !out_expired)
    else $error("record expired with zero step");

  // Input backpressure only appears when the output side is blocked.
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low while pipeline can drain");

  // A blocked output with a full pipeline stays full in the next cycle.
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> out_valid)
    else $error("pipeline lost a record during stall");

endmodule

FILE: tb/particle_euler_update_test.sv
// Self-checking testbench for the particle Euler update pipeline.
module particle_euler_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DT_W     = peu_pkg::DT_W;
  localparam int     AGE_W    = peu_pkg::AGE_W;
  localparam int     VAL_W    = peu_pkg::VAL_W;
  localparam int     TS_RESET = peu_pkg::TS_RESET;

  typedef peu_pkg::peu_in_t  peu_in_t;
  typedef peu_pkg::peu_rec_t peu_rec_t;

  localparam int     FB       = peu_pkg::FRAC_BITS_DEF;
  localparam longint ONE_Q    = 64'sd1 << FB;
  localparam longint DT_CAP   = 64'sd1 << (FB - 2);
  localparam longint GRAV_Q   = (981 * ONE_Q + 50) / 100;
  localparam longint AGE_MAX  = 64'sh7FFF_FFFF;
  localparam longint Q_MAX    = 64'sh7FFF_FFFF;
  localparam longint Q_MIN    = -64'sh8000_0000;

  // Holds the time step the block should be using, predicts each particle
  // update and checks the block's results against them in order.
  class particle_update_board;
    bit [DT_W-1:0] step;
    peu_rec_t      pending_updates[$];
    int            mismatches;
    int            updates_checked;
    int            expired_seen;

    function new();
      step = DT_W'(TS_RESET);
    endfunction

    function longint clamp32(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function longint sx(logic [VAL_W-1:0] v);
      return longint'($signed(v));
    endfunction

    function peu_rec_t predict_update(peu_in_t p);
      peu_rec_t r;
      longint   dt, age_next, damp, gstep, vx, vy, vz;
      r = '0;
      if (step == 0) begin
        r.age   = p.age_now;
        r.pos_x = p.pos_x;
        r.pos_y = p.pos_y;
        r.pos_z = p.pos_z;
        r.vel_x = p.vel_x;
        r.vel_y = p.vel_y;
        r.vel_z = p.vel_z;
        r.angle = p.angle;
        return r;
      end
      dt = (longint'(step) > DT_CAP) ? DT_CAP : longint'(step);
      age_next = longint'(p.age_now) + dt;
      if (age_next > AGE_MAX) age_next = AGE_MAX;
      r.age = AGE_W'(age_next);
      if (age_next >= longint'(p.lifetime)) begin
        r.expired = 1'b1;
        return r;
      end
      damp = ONE_Q - ((longint'(p.drag_coeff) * dt) >>> FB);
      if (damp < 0) damp = 0;
      // Gravity is floored once after the scale and once after the step.
      gstep = ((((-GRAV_Q) * sx(p.gravity_scale)) >>> FB) * dt) >>> FB;
      vy = clamp32(sx(p.vel_y) + gstep);
      vx = clamp32((sx(p.vel_x) * damp) >>> FB);
      vy = clamp32((vy * damp) >>> FB);
      vz = clamp32((sx(p.vel_z) * damp) >>> FB);
      r.vel_x = VAL_W'(vx);
      r.vel_y = VAL_W'(vy);
      r.vel_z = VAL_W'(vz);
      r.pos_x = VAL_W'(clamp32(sx(p.pos_x) + ((vx * dt) >>> FB)));
      r.pos_y = VAL_W'(clamp32(sx(p.pos_y) + ((vy * dt) >>> FB)));
      r.pos_z = VAL_W'(clamp32(sx(p.pos_z) + ((vz * dt) >>> FB)));
      r.angle = VAL_W'(clamp32(sx(p.angle) + ((sx(p.spin_rate) * dt) >>> FB)));
      return r;
    endfunction

    function void note_particle(peu_in_t p);
      pending_updates.insert(pending_updates.size(), predict_update(p));
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] want,
                                logic [VAL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_update(peu_rec_t got);
      peu_rec_t want;
      if (pending_updates.size() == 0) begin
        $error("result transaction with no update pending");
        mismatches++;
        return;
      end
      want = pending_updates.pop_front();
      updates_checked++;
      if (want.expired) expired_seen++;
      compare_field("expired", VAL_W'(want.expired), VAL_W'(got.expired));
      compare_field("new_age", VAL_W'(want.age), VAL_W'(got.age));
      compare_field("new_pos_x", want.pos_x, got.pos_x);
      compare_field("new_pos_y", want.pos_y, got.pos_y);
      compare_field("new_pos_z", want.pos_z, got.pos_z);
      compare_field("new_vel_x", want.vel_x, got.vel_x);
      compare_field("new_vel_y", want.vel_y, got.vel_y);
      compare_field("new_vel_z", want.vel_z, got.vel_z);
      compare_field("new_angle", want.angle, got.angle);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [DT_W-1:0]         cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [AGE_W-1:0]        in_age_now;
  logic [AGE_W-1:0]        in_lifetime;
  logic signed [31:0]      in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0]      in_vel_x, in_vel_y, in_vel_z;
  logic signed [31:0]      in_angle, in_spin_rate;
  logic [AGE_W-1:0]        in_drag_coeff;
  logic signed [31:0]      in_gravity_scale;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_expired;
  logic [AGE_W-1:0]        out_new_age;
  logic signed [31:0]      out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [31:0]      out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic signed [31:0]      out_new_angle;

  particle_update_board board;
  bit                   src_gaps;
  bit                   sink_stalls;
  int                   particles_sent;
  int                   step_settings;

  particle_euler_update dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_age_now       (in_age_now),
    .in_lifetime      (in_lifetime),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_vel_z         (in_vel_z),
    .in_angle         (in_angle),
    .in_spin_rate     (in_spin_rate),
    .in_drag_coeff    (in_drag_coeff),
    .in_gravity_scale (in_gravity_scale),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_expired      (out_expired),
    .out_new_age      (out_new_age),
    .out_new_pos_x    (out_new_pos_x),
    .out_new_pos_y    (out_new_pos_y),
    .out_new_pos_z    (out_new_pos_z),
    .out_new_vel_x    (out_new_vel_x),
    .out_new_vel_y    (out_new_vel_y),
    .out_new_vel_z    (out_new_vel_z),
    .out_new_angle    (out_new_angle)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Moderate values in half of the draws so the arithmetic stays in range, with the
  // extremes and full-width values mixed in.
  function automatic logic [VAL_W-1:0] rand_q();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  function automatic peu_in_t rand_particle();
    peu_in_t p;
    int      kind;
    p.pos_x     = rand_q();
    p.pos_y     = rand_q();
    p.pos_z     = rand_q();
    p.vel_x     = rand_q();
    p.vel_y     = rand_q();
    p.vel_z     = rand_q();
    p.angle     = rand_q();
    p.spin_rate = rand_q();
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      p.age_now  = AGE_W'($urandom_range(0, 32'h0FFF_FFFF));
      p.lifetime = p.age_now + AGE_W'($urandom_range(20000, 32'h00FF_FFFF));
    end else if (kind < 17) begin
      // Lifetime close to the new age, on either side of the expiry edge.
      p.age_now  = AGE_W'($urandom_range(0, 32'h0FFF_FFFF));
      p.lifetime = p.age_now + AGE_W'($urandom_range(0, 20000));
    end else if (kind < 19) begin
      p.age_now  = AGE_W'($urandom);
      p.lifetime = AGE_W'($urandom);
    end else begin
      p.age_now  = 31'h7FFF_FFFF - AGE_W'($urandom_range(0, 20000));
      p.lifetime = ($urandom_range(0, 1) == 1) ? 31'h7FFF_FFFF : AGE_W'($urandom);
    end
    case ($urandom_range(0, 9))
      0: p.drag_coeff = AGE_W'($urandom);
      1: p.drag_coeff = 31'h7FFF_FFFF;
      default: p.drag_coeff = AGE_W'($urandom_range(0, 32'h000F_FFFF));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      p.gravity_scale = rand_q();
    end else begin
      p.gravity_scale = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
    end
    return p;
  endfunction

  // Leaves in_valid high so back-to-back transactions need no gap.
  task automatic send_particle(input peu_in_t p);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_age_now       <= p.age_now;
    in_lifetime      <= p.lifetime;
    in_pos_x         <= p.pos_x;
    in_pos_y         <= p.pos_y;
    in_pos_z         <= p.pos_z;
    in_vel_x         <= p.vel_x;
    in_vel_y         <= p.vel_y;
    in_vel_z         <= p.vel_z;
    in_angle         <= p.angle;
    in_spin_rate     <= p.spin_rate;
    in_drag_coeff    <= p.drag_coeff;
    in_gravity_scale <= p.gravity_scale;
    do @(posedge clk); while (!in_ready);
    board.note_particle(p);
    particles_sent++;
  endtask

  task automatic wait_drained();
    while (board.pending_updates.size() != 0) @(posedge clk);
  endtask

  // Every particle yields one result, so an empty queue means an idle pipeline.
  task automatic write_step(input logic [DT_W-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.step = v;
    cfg_valid <= 1'b0;
    step_settings++;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        src_gaps    = $urandom_range(0, 1);
        sink_stalls = $urandom_range(0, 1);
      end
      send_particle(rand_particle());
    end
  endtask

  task automatic run_directed();
    peu_in_t p;
    // Still particle with a long life: only the age moves.
    p = '0;
    p.lifetime = 31'h7FFF_FFFF;
    send_particle(p);
    // Zero lifetime expires at once.
    p.lifetime = '0;
    send_particle(p);
    // Age saturates at the top and the particle expires.
    p = '1;
    send_particle(p);
    // Age close to the top, still alive, all values at the positive limit but a negative-limit gravity scale.
    p = '0;
    p.age_now   = 31'h7FFF_FFFF - AGE_W'(2000);
    p.lifetime  = 31'h7FFF_FFFF;
    p.pos_x     = 32'h7FFF_FFFF;
    p.pos_y     = 32'h7FFF_FFFF;
    p.pos_z     = 32'h7FFF_FFFF;
    p.vel_x     = 32'h7FFF_FFFF;
    p.vel_y     = 32'h7FFF_FFFF;
    p.vel_z     = 32'h7FFF_FFFF;
    p.angle     = 32'h7FFF_FFFF;
    p.spin_rate = 32'h7FFF_FFFF;
    p.gravity_scale = 32'h8000_0000;
    send_particle(p);
    // Negative limits with strong downward gravity scale.
    p.pos_x     = 32'h8000_0000;
    p.pos_y     = 32'h8000_0000;
    p.pos_z     = 32'h8000_0000;
    p.vel_x     = 32'h8000_0000;
    p.vel_y     = 32'h8000_0000;
    p.vel_z     = 32'h8000_0000;
    p.angle     = 32'h8000_0000;
    p.spin_rate = 32'h8000_0000;
    p.gravity_scale = 32'h7FFF_FFFF;
    send_particle(p);
    // Heavy drag drives the damping factor to zero.
    p.drag_coeff = 31'h7FFF_FFFF;
    send_particle(p);
    // Age lands exactly on the lifetime.
    p = '0;
    p.age_now  = AGE_W'(1000);
    p.lifetime = AGE_W'(1000 + TS_RESET);
    p.vel_y    = 32'h0001_0000;
    p.gravity_scale = 32'h0001_0000;
    send_particle(p);
    // One unit short of the lifetime: still alive, normal drag and gravity.
    p.lifetime   = AGE_W'(1001 + TS_RESET);
    p.drag_coeff = 31'h0000_8000;
    p.vel_x      = 32'hFFFE_8000;
    p.vel_z      = 32'h0003_4000;
    p.pos_x      = 32'h0010_0000;
    p.spin_rate  = 32'h0006_487F;
    send_particle(p);
  endtask

  task automatic run_zero_step_directed();
    peu_in_t p;
    // With no step even a zero lifetime must not expire.
    p = '0;
    p.pos_x = 32'h8000_0000;
    p.vel_y = 32'h7FFF_FFFF;
    send_particle(p);
    p = '1;
    send_particle(p);
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    peu_rec_t got;
    if (rst_n && out_valid && out_ready) begin
      got.expired = out_expired;
      got.age     = out_new_age;
      got.pos_x   = out_new_pos_x;
      got.pos_y   = out_new_pos_y;
      got.pos_z   = out_new_pos_z;
      got.vel_x   = out_new_vel_x;
      got.vel_y   = out_new_vel_y;
      got.vel_z   = out_new_vel_z;
      got.angle   = out_new_angle;
      board.check_update(got);
    end
  end

  initial begin
    board = new();
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_age_now       <= '0;
    in_lifetime      <= '0;
    in_pos_x         <= '0;
    in_pos_y         <= '0;
    in_pos_z         <= '0;
    in_vel_x         <= '0;
    in_vel_y         <= '0;
    in_vel_z         <= '0;
    in_angle         <= '0;
    in_spin_rate     <= '0;
    in_drag_coeff    <= '0;
    in_gravity_scale <= '0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    step_settings = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset step is checked before any write.
    run_directed();
    run_random(140);
    write_step('0);
    run_zero_step_directed();
    run_random(100);
    write_step(15'h7FFF);
    run_random(140);
    write_step(15'd16384);
    run_random(120);
    write_step(15'd1);
    run_random(120);
    write_step(DT_W'($urandom_range(2, 16383)));
    run_random(140);
    write_step(DT_W'($urandom_range(16385, 32767)));
    run_random(100);
    // Closing stretch runs at full rate on both sides.
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    write_step(DT_W'($urandom_range(1, 4000)));
    for (int i = 0; i < 180; i++) send_particle(rand_particle());
    in_valid <= 1'b0;

    wait_drained();
    repeat (12) @(posedge clk);
    $display("Sent %0d particle records under %0d time step settings.",
             particles_sent, step_settings);
    $display("Checked %0d updates, %0d of them expired, %0d field mismatches.",
             board.updates_checked, board.expired_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/peu_pkg.sv
rtl/core/peu_cfg.sv
rtl/core/peu_dyn.sv
rtl/core/peu_vel.sv
rtl/core/peu_pos.sv
rtl/core/particle_euler_update.sv
tb/particle_euler_update_test.sv
